FILE: sv/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg: shared types and constants of the register machine execute unit
// Opcode codes, field widths and the decoded instruction record that the
// front part hands to the back part through its queue.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int KIND_W    = 4;
  localparam int REG_IDX_W = 3;
  localparam int WORD_W    = 32;
  localparam int TGT_W     = 16;
  localparam int LEN_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    OP_HLT  = 4'd0,
    OP_MOVL = 4'd1,
    OP_OUT  = 4'd2,
    OP_ADD  = 4'd3,
    OP_MUL  = 4'd4,
    OP_CMP  = 4'd5,
    OP_JIGT = 4'd6,
    OP_JILT = 4'd7,
    OP_JIET = 4'd8
  } op_t;

  // Instruction lengths in program words.
  localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

  typedef struct packed {
    op_t                  op;
    logic [LEN_W-1:0]     len;
    logic [REG_IDX_W-1:0] dest;
    logic [REG_IDX_W-1:0] src;
    logic [WORD_W-1:0]    literal;
    logic [TGT_W-1:0]     target;
  } instr_t;

endpackage

FILE: sv/rme_front.sv
// ----------------------------------------------------------------------------
// rme_front: instruction intake and classification
// Takes input beats, works out each instruction's length and keeps the
// decoded records in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module rme_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rme_pkg::KIND_W-1:0]      in_kind,
  input  logic [rme_pkg::REG_IDX_W-1:0]   in_dest_reg,
  input  logic [rme_pkg::REG_IDX_W-1:0]   in_src_reg,
  input  logic signed [rme_pkg::WORD_W-1:0] in_literal,
  input  logic [rme_pkg::TGT_W-1:0]       in_jump_target,
  output logic                            q_valid,
  input  logic                            q_ready,
  output rme_pkg::instr_t                 q_instr
);
  import rme_pkg::*;

  instr_t      dec;
  instr_t      slot_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  always_comb begin
    dec.op      = op_t'(in_kind);
    dec.dest    = in_dest_reg;
    dec.src     = in_src_reg;
    dec.literal = in_literal;
    dec.target  = in_jump_target;
    unique case (dec.op)
      OP_MOVL, OP_ADD, OP_MUL, OP_CMP: dec.len = LEN_THREE;
      OP_OUT, OP_JIGT, OP_JILT, OP_JIET: dec.len = LEN_TWO;
      default: dec.len = LEN_ONE;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_instr  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count missed a push");
`endif

endmodule

FILE: sv/rme_back.sv
// ----------------------------------------------------------------------------
// rme_back: operand read, execution and result register
// Reads the register file one stage ahead with forwarding, then executes,
// updates the machine state and loads the output register.
// ----------------------------------------------------------------------------
module rme_back #(
  parameter int NUM_REGS  = 8,
  parameter int ADDR_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  rme_pkg::instr_t                   q_instr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rme_pkg::TGT_W-1:0]         out_next_pc,
  output logic                              out_out_valid,
  output logic signed [rme_pkg::WORD_W-1:0] out_out_value,
  output logic                              out_halted
);
  import rme_pkg::*;

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [WORD_W-1:0]    rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0]  rf_vld_r;

  // Operand stage
  logic                 s1_v_r;
  instr_t               s1_r;
  logic [WORD_W-1:0]    a_mem_r, b_mem_r;
  logic                 a_fwd_r, b_fwd_r, a_zero_r, b_zero_r;

  // Machine state
  logic [WORD_W-1:0]    diff_r;
  logic [ADDR_BITS-1:0] pc_r;
  logic                 halt_r;
  logic [WORD_W-1:0]    wb_data_r;

  // Output register
  logic                 out_v_r;
  logic [TGT_W-1:0]     out_pc_r;
  logic                 out_ov_r;
  logic [WORD_W-1:0]    out_val_r;
  logic                 out_h_r;

  logic                 s1_adv, load;
  logic [REG_IDX_W:0]   qa_ext, qb_ext, wa_ext;
  logic [IDX_W-1:0]     qa_idx, qb_idx, wr_idx;
  logic                 qa_ok, qb_ok, wr_ok;
  logic [WORD_W-1:0]    opa, opb, sum, prod, dif;
  logic                 wr_en, take, neg;
  logic [WORD_W-1:0]    wr_data;
  logic [ADDR_BITS-1:0] pc_nxt, tgt_ext;

  assign s1_adv  = s1_v_r && (!out_v_r || out_ready);
  assign load    = q_valid && (!s1_v_r || s1_adv);
  assign q_ready = !s1_v_r || s1_adv;

  assign qa_ext = {1'b0, q_instr.dest};
  assign qb_ext = {1'b0, q_instr.src};
  assign wa_ext = {1'b0, s1_r.dest};
  assign qa_idx = qa_ext[IDX_W-1:0];
  assign qb_idx = qb_ext[IDX_W-1:0];
  assign wr_idx = wa_ext[IDX_W-1:0];
  assign qa_ok  = int'(q_instr.dest) < NUM_REGS;
  assign qb_ok  = int'(q_instr.src) < NUM_REGS;
  assign wr_ok  = int'(s1_r.dest) < NUM_REGS;

  // Operands: forwarded write, stored word, or zero for an absent or unwritten register.
  assign opa = a_fwd_r ? wb_data_r : (a_zero_r ? '0 : a_mem_r);
  assign opb = b_fwd_r ? wb_data_r : (b_zero_r ? '0 : b_mem_r);
  assign sum  = opa + opb;
  assign prod = opa * opb;
  assign dif  = opa - opb;
  assign neg  = diff_r[WORD_W-1];
  assign tgt_ext = ADDR_BITS'(s1_r.target);

  always_comb begin
    take    = 1'b0;
    wr_en   = 1'b0;
    wr_data = s1_r.literal;
    unique case (s1_r.op)
      OP_MOVL: begin
        wr_en   = 1'b1;
        wr_data = s1_r.literal;
      end
      OP_ADD: begin
        wr_en   = 1'b1;
        wr_data = sum;
      end
      OP_MUL: begin
        wr_en   = 1'b1;
        wr_data = prod;
      end
      OP_JIGT: take = (diff_r != '0) && !neg;
      OP_JILT: take = neg;
      OP_JIET: take = (diff_r == '0);
      default: take = 1'b0;
    endcase
    wr_en  = wr_en && wr_ok && s1_adv && !halt_r;
    pc_nxt = take ? tgt_ext : pc_r + ADDR_BITS'(s1_r.len);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[wr_idx] <= wr_data;
    end
    if (load) begin
      a_mem_r <= rf_mem[qa_idx];
      b_mem_r <= rf_mem[qb_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r     <= q_instr;
      a_fwd_r  <= wr_en && qa_ok && (wr_idx == qa_idx);
      b_fwd_r  <= wr_en && qb_ok && (wr_idx == qb_idx);
      a_zero_r <= !qa_ok || !rf_vld_r[qa_idx];
      b_zero_r <= !qb_ok || !rf_vld_r[qb_idx];
    end
    if (wr_en) begin
      wb_data_r <= wr_data;
    end
    if (s1_adv) begin
      out_ov_r  <= !halt_r && (s1_r.op == OP_OUT);
      out_val_r <= (!halt_r && (s1_r.op == OP_OUT)) ? opa : '0;
      out_pc_r  <= halt_r ? TGT_W'(pc_r) : TGT_W'(pc_nxt);
      out_h_r   <= halt_r || (s1_r.op == OP_HLT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      s1_v_r   <= 1'b0;
      diff_r   <= '0;
      pc_r     <= '0;
      halt_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        rf_vld_r[wr_idx] <= 1'b1;
      end
      if (load) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv && !halt_r) begin
        pc_r <= pc_nxt;
        if (s1_r.op == OP_CMP) begin
          diff_r <= dif;
        end
        if (s1_r.op == OP_HLT) begin
          halt_r <= 1'b1;
        end
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_v_r;
  assign out_next_pc   = out_pc_r;
  assign out_out_valid = out_ov_r;
  assign out_out_value = out_val_r;
  assign out_halted    = out_h_r;

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");
  a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> ($stable(pc_r) && $stable(diff_r) && $stable(rf_vld_r)))
    else $error("machine state changed after halt");
  a_out_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ov_r) |-> !out_h_r)
    else $error("output value reported on a halted beat");
`endif

endmodule

FILE: sv/register_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// register_machine_execute_unit: execute stage of a small register machine
// Runs one fetched instruction per input beat and returns one result beat
// with the next program counter, an optional output value and halt status.
// ----------------------------------------------------------------------------
// Usage: instructions arrive on the in_ channel (valid/ready); each accepted
// beat yields exactly one beat on the out_ channel, in order. Note that the
// result field out_out_valid is payload, distinct from the out_valid strobe.
// Acceptance writes an instruction into the intake queue; as it leaves the
// queue, its operands are read from the register file (with forwarding from
// the instruction just executed) into the operand stage, and the execute step
// then loads the output register. Throughput is one instruction per cycle
// while out_ready stays high, with the 32x32 multiply done in the execute step.
// A two-entry queue sits between intake and execution, so in_ready depends
// only on its fill level. When the receiver stalls, the output register
// holds its beat, the operand stage then fills and the queue absorbs two
// further beats before in_ready falls. Reset (synchronous, rst_n low) clears
// the compare difference, the program counter and the halt flag; register
// contents are marked unwritten and read as zero. After a halt instruction,
// later beats leave the state untouched.
// ----------------------------------------------------------------------------
module register_machine_execute_unit #(
  parameter int NUM_REGS  = 8,
  parameter int ADDR_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rme_pkg::KIND_W-1:0]        in_kind,
  input  logic [rme_pkg::REG_IDX_W-1:0]     in_dest_reg,
  input  logic [rme_pkg::REG_IDX_W-1:0]     in_src_reg,
  input  logic signed [rme_pkg::WORD_W-1:0] in_literal,
  input  logic [rme_pkg::TGT_W-1:0]         in_jump_target,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rme_pkg::TGT_W-1:0]         out_next_pc,
  output logic                              out_out_valid,
  output logic signed [rme_pkg::WORD_W-1:0] out_out_value,
  output logic                              out_halted
);
  import rme_pkg::*;

  // Decoded instructions travel from the intake queue to the back part.
  logic   q_valid;
  logic   q_ready;
  instr_t q_instr;

  rme_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_dest_reg   (in_dest_reg),
    .in_src_reg    (in_src_reg),
    .in_literal    (in_literal),
    .in_jump_target(in_jump_target),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_instr       (q_instr)
  );

  // The back part owns all architectural state and the result register.
  rme_back #(
    .NUM_REGS (NUM_REGS),
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_instr      (q_instr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_next_pc  (out_next_pc),
    .out_out_valid(out_out_valid),
    .out_out_value(out_out_value),
    .out_halted   (out_halted)
  );

endmodule
